// ===== hdl/pks_pkg.sv =====
// ============================================================================
// pks_pkg: shared types and constants of the pose smoother
// Payload structs, word sizes and configuration register indexes.
// ============================================================================
`default_nettype none

package pks_pkg;

    localparam int WORD_W    = 32;
    localparam int CHANNELS  = 6;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_COV      = 2'd2;

    localparam logic [WORD_W-1:0] PROCESS_NOISE_RST = 32'd65;
    localparam logic [WORD_W-1:0] MEAS_NOISE_RST    = 32'd6554;
    localparam logic [WORD_W-1:0] INIT_COV_RST      = 32'd65536;

    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef struct packed {
        logic signed [WORD_W-1:0] meas_x;
        logic signed [WORD_W-1:0] meas_y;
        logic signed [WORD_W-1:0] meas_z;
        logic signed [WORD_W-1:0] meas_roll;
        logic signed [WORD_W-1:0] meas_pitch;
        logic signed [WORD_W-1:0] meas_yaw;
    } t_meas;

    typedef struct packed {
        logic signed [WORD_W-1:0] est_x;
        logic signed [WORD_W-1:0] est_y;
        logic signed [WORD_W-1:0] est_z;
        logic signed [WORD_W-1:0] est_roll;
        logic signed [WORD_W-1:0] est_pitch;
        logic signed [WORD_W-1:0] est_yaw;
    } t_est;

endpackage

`default_nettype wire

// ===== hdl/pks_gain_div.sv =====
// ============================================================================
// pks_gain_div: Kalman gain divider
// Restoring divider, one quotient bit per cycle:
// gain = floor((ppre << FRAC_BITS) / (ppre + r)), zero when the sum is zero.
// ============================================================================
`default_nettype none

module pks_gain_div
    import pks_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [WORD_W-1:0]    i_ppre,
    input  logic [WORD_W-1:0]    i_meas_noise,
    output logic                 o_done,
    output logic [FRAC_BITS:0]   o_gain
);

    localparam int GW    = FRAC_BITS + 1;
    localparam int DEN_W = WORD_W + 1;
    localparam int REM_W = WORD_W + 2;
    localparam int CW    = $clog2(FRAC_BITS + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DEN_W-1:0] r_den;
    logic [REM_W-1:0] r_rem;
    logic [GW-1:0]    r_quo;

    logic             w_ge;
    logic [REM_W-1:0] w_sub;
    logic [REM_W-1:0] w_next;

    // ppre <= den, so the quotient never needs more than FRAC_BITS+1 bits
    assign w_ge   = r_rem >= {1'b0, r_den};
    assign w_sub  = r_rem - {1'b0, r_den};
    assign w_next = w_ge ? w_sub : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(FRAC_BITS);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {2'b00, i_ppre};
            r_den <= {1'b0, i_ppre} + {1'b0, i_meas_noise};
        end else if (r_busy) begin
            r_quo <= {r_quo[GW-2:0], w_ge};
            r_rem <= {w_next[REM_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_gain = (r_den == '0) ? '0 : r_quo;

endmodule

`default_nettype wire

// ===== hdl/pks_mul.sv =====
// ============================================================================
// pks_mul: shared unsigned multiplier
// One registered product per cycle; used for every channel and for P.
// ============================================================================
`default_nettype none

module pks_mul
#(
    parameter int A_W = 33,
    parameter int B_W = 17
)
(
    input  logic                 i_clk,
    input  logic [A_W-1:0]       i_a,
    input  logic [B_W-1:0]       i_b,
    output logic [A_W+B_W-1:0]   o_prod
);

    logic [A_W+B_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== hdl/pose_kalman_smoother_unit.sv =====
// ============================================================================
// pose_kalman_smoother_unit: scalar-covariance Kalman smoother for a pose
// Six estimates share one error covariance P; a sequencer runs a bit-serial
// gain divider and one shared multiplier over the channels.
// ============================================================================
//  channel | signals                                  | handshake
//  --------+------------------------------------------+------------------
//  input   | i_meas_valid, o_meas_stall, i_meas       | valid / stall
//  output  | o_est_valid, i_est_stall, o_est          | valid / stall
//  config  | i_cfg_valid, o_cfg_ready, i_cfg_index,   | valid / ready
//          | i_cfg_data                               |
//
// Per item, the divider yields one gain bit per cycle, then each channel
// takes its turn on the shared multiplier (S_DIFF, S_MUL, S_UPD), then
// one multiply updates P.
// o_meas_stall is high from acceptance until the result is loaded into the
// output register; a held result blocks only that final load.
// Reset loads the register defaults and clears the primed flag.
// ============================================================================
`default_nettype none

module pose_kalman_smoother_unit
    import pks_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_meas_valid,
    output logic                  o_meas_stall,
    input  t_meas                 i_meas,
    output logic                  o_est_valid,
    input  logic                  i_est_stall,
    output t_est                  o_est,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [WORD_W-1:0]     i_cfg_data
);

    localparam int GW    = FRAC_BITS + 1;
    localparam int MAG_W = WORD_W + 1;
    localparam int PW    = MAG_W + GW;
    localparam int RW    = PW - FRAC_BITS;
    localparam int SUM_W = RW + 2;
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam logic [GW-1:0] ONE_Q = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [PW-1:0] HALF  = PW'(1) << (FRAC_BITS - 1);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_PPRE   = 10'b00_0000_0010,
        S_DSTART = 10'b00_0000_0100,
        S_DIV    = 10'b00_0000_1000,
        S_DIFF   = 10'b00_0001_0000,
        S_MUL    = 10'b00_0010_0000,
        S_UPD    = 10'b00_0100_0000,
        S_PMUL   = 10'b00_1000_0000,
        S_PUPD   = 10'b01_0000_0000,
        S_OUT    = 10'b10_0000_0000
    } t_state;

    t_state            r_state, n_state;

    logic [WORD_W-1:0] r_q_noise;
    logic [WORD_W-1:0] r_r_noise;
    logic [WORD_W-1:0] r_p_init;
    logic              r_primed;
    logic [WORD_W-1:0] r_p;
    logic [WORD_W-1:0] r_ppre;
    logic [GW-1:0]     r_gain;
    logic [CH_W-1:0]   r_ch;
    logic              r_neg;
    logic [MAG_W-1:0]  r_mag;
    t_word             r_meas [CHANNELS];
    t_word             r_est  [CHANNELS];
    logic              r_o_valid;
    t_est              r_o_est;

    t_word             w_in [CHANNELS];
    logic              w_accept;
    logic              w_last_ch;
    logic [WORD_W:0]   w_psum;
    logic [WORD_W-1:0] w_ppre;
    logic              w_div_done;
    logic [GW-1:0]     w_div_gain;
    logic [MAG_W-1:0]  w_diff;
    logic [MAG_W-1:0]  w_mul_a;
    logic [GW-1:0]     w_mul_b;
    logic [PW-1:0]     w_prod;
    logic [PW-1:0]     w_rnd_full;
    logic [SUM_W-1:0]  w_rnd;
    logic [SUM_W-1:0]  w_sum;
    t_word             w_upd;
    logic              w_out_load;

    assign w_in[0] = i_meas.meas_x;
    assign w_in[1] = i_meas.meas_y;
    assign w_in[2] = i_meas.meas_z;
    assign w_in[3] = i_meas.meas_roll;
    assign w_in[4] = i_meas.meas_pitch;
    assign w_in[5] = i_meas.meas_yaw;

    assign w_accept   = (r_state == S_IDLE) && i_meas_valid;
    assign w_last_ch  = (r_ch == CH_W'(CHANNELS - 1));
    assign w_out_load = (r_state == S_OUT) && (!r_o_valid || !i_est_stall);

    // saturating P + q
    assign w_psum = {1'b0, r_p} + {1'b0, r_q_noise};
    assign w_ppre = w_psum[WORD_W] ? '1 : w_psum[WORD_W-1:0];

    // 33-bit signed innovation
    assign w_diff = {r_meas[r_ch][WORD_W-1], r_meas[r_ch]}
                  - {r_est[r_ch][WORD_W-1], r_est[r_ch]};

    assign w_mul_a = (r_state == S_PMUL) ? {1'b0, r_ppre} : r_mag;
    assign w_mul_b = (r_state == S_PMUL) ? (ONE_Q - r_gain) : r_gain;

    pks_gain_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (r_state == S_DSTART),
        .i_ppre       (r_ppre),
        .i_meas_noise (r_r_noise),
        .o_done       (w_div_done),
        .o_gain       (w_div_gain)
    );

    pks_mul #(
        .A_W (MAG_W),
        .B_W (GW)
    ) u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // round magnitude half away from zero, restore sign, add, saturate
    always_comb begin
        w_rnd_full = w_prod + HALF;
        w_rnd      = SUM_W'(w_rnd_full[PW-1:FRAC_BITS]);
        if (r_neg) begin
            w_rnd = -w_rnd;
        end
        w_sum = {{(SUM_W-WORD_W){r_est[r_ch][WORD_W-1]}}, r_est[r_ch]} + w_rnd;
        if (w_sum[SUM_W-1:WORD_W-1] == '0 || w_sum[SUM_W-1:WORD_W-1] == '1) begin
            w_upd = w_sum[WORD_W-1:0];
        end else if (w_sum[SUM_W-1]) begin
            w_upd = WORD_MIN;
        end else begin
            w_upd = WORD_MAX;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_meas_valid) n_state = S_PPRE;
            S_PPRE:   n_state = S_DSTART;
            S_DSTART: n_state = S_DIV;
            S_DIV:    if (w_div_done) n_state = S_DIFF;
            S_DIFF:   n_state = S_MUL;
            S_MUL:    n_state = S_UPD;
            S_UPD:    n_state = w_last_ch ? S_PMUL : S_DIFF;
            S_PMUL:   n_state = S_PUPD;
            S_PUPD:   n_state = S_OUT;
            S_OUT:    if (w_out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_q_noise <= PROCESS_NOISE_RST;
            r_r_noise <= MEAS_NOISE_RST;
            r_p_init  <= INIT_COV_RST;
            r_primed  <= 1'b0;
            r_p       <= INIT_COV_RST;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PROCESS_NOISE: r_q_noise <= i_cfg_data;
                    CFG_MEAS_NOISE:    r_r_noise <= i_cfg_data;
                    CFG_INIT_COV:      r_p_init  <= i_cfg_data;
                    default:           ;
                endcase
            end
            if (w_accept && !r_primed) begin
                r_primed <= 1'b1;
                r_p      <= r_p_init;
            end
            if (r_state == S_PUPD) begin
                r_p <= w_prod[FRAC_BITS +: WORD_W];
            end
            if (w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_est_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_meas[i] <= w_in[i];
                if (!r_primed) begin
                    r_est[i] <= w_in[i];
                end
            end
        end
        if (r_state == S_PPRE) begin
            r_ppre <= w_ppre;
        end
        if (r_state == S_DIV && w_div_done) begin
            r_gain <= w_div_gain;
            r_ch   <= '0;
        end
        if (r_state == S_DIFF) begin
            r_neg <= w_diff[MAG_W-1];
            r_mag <= w_diff[MAG_W-1] ? -w_diff : w_diff;
        end
        if (r_state == S_UPD) begin
            r_est[r_ch] <= w_upd;
            r_ch        <= r_ch + 1'b1;
        end
        if (w_out_load) begin
            r_o_est.est_x     <= r_est[0];
            r_o_est.est_y     <= r_est[1];
            r_o_est.est_z     <= r_est[2];
            r_o_est.est_roll  <= r_est[3];
            r_o_est.est_pitch <= r_est[4];
            r_o_est.est_yaw   <= r_est[5];
        end
    end

    assign o_meas_stall = (r_state != S_IDLE);
    assign o_est_valid  = r_o_valid;
    assign o_est        = r_o_est;
    assign o_cfg_ready  = 1'b1;

endmodule

`default_nettype wire

// ===== hdl/pks_checker.sv =====
// ============================================================================
// pks_checker: port-level checks for the pose smoother
// Watches the top-level ports only; bound to every instance of the top.
// ============================================================================
`default_nettype none

module pks_checker
    import pks_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_meas_valid,
    input  logic                  o_meas_stall,
    input  logic                  o_est_valid,
    input  logic                  i_est_stall,
    input  t_est                  o_est
);

    logic w_in_acc;
    assign w_in_acc = i_meas_valid && !o_meas_stall;

    // held result keeps valid and payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_est_valid && i_est_stall |=> o_est_valid && $stable(o_est))
        else $error("held result changed");

    // an accepted item keeps the input side busy
    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_meas_stall)
        else $error("input not stalled after item accepted");

    // no result can appear in the cycle after an item is taken
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> !$rose(o_est_valid))
        else $error("result appeared right after accept");

    // a new result arrives together with the input side opening
    a_result_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_est_valid) |-> !o_meas_stall)
        else $error("result loaded while still busy");

endmodule

bind pose_kalman_smoother_unit pks_checker u_pks_checker (.*);

`default_nettype wire
